// File: design/psgtn_pkg.sv
// ----------------------------------------------------------------------------
// psgtn_pkg
// Shared types and constants for the three-voice tone/noise mixer.
// ----------------------------------------------------------------------------
package psgtn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 40;
	localparam int STEP_W    = 24;
	localparam int CMP_W     = ((ACC_W > FRAC_BITS + 17) ? ACC_W : FRAC_BITS + 17) + 1;
	localparam int SMP_W     = 6;
	localparam int NREG      = 16;
	localparam int IDX_W     = 4;
	localparam int LFSR_W    = 17;

	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [STEP_W-1:0] STEP_RESET      = STEP_W'(336975);
	localparam logic [ACC_W-1:0]  NOISE_ACC_RESET = ACC_W'(64'h46326231);

	localparam logic [IDX_W-1:0]  REG_NOISE_PER = IDX_W'(6);
	localparam logic [IDX_W-1:0]  REG_MIXER     = IDX_W'(7);

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_TICK  = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [7:0]       val;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

endpackage

// File: design/psgtn_if.sv
// ----------------------------------------------------------------------------
// psgtn_if
// Valid/ready channel interfaces: requests, samples and step configuration.
// ----------------------------------------------------------------------------
interface psgtn_req_if import psgtn_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [IDX_W-1:0] reg_index;
	logic [7:0]       reg_value;

	modport source(output valid, req_type, reg_index, reg_value, input ready);
	modport sink(input valid, req_type, reg_index, reg_value, output ready);
endinterface

interface psgtn_smp_if import psgtn_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] sample;

	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface

interface psgtn_cfg_if import psgtn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] phase_step;

	modport source(output valid, phase_step, input ready);
	modport sink(input valid, phase_step, output ready);
endinterface

// File: design/psgtn_front.sv
// ----------------------------------------------------------------------------
// psgtn_front
// Accepts requests, decodes kind and noise-period fixup, queues for the back.
// ----------------------------------------------------------------------------
module psgtn_front import psgtn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	psgtn_req_if.sink   req,
	output q_head_t     head,
	input  logic        pop
);

	q_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	q_item_t           item;
	logic              push;

	always_comb begin
		item.kind = req.req_type ? REQ_TICK : REQ_WRITE;
		item.idx  = req.reg_index;
		item.val  = req.reg_value;
		if (req.reg_index == REG_NOISE_PER && req.reg_value == 8'd0) begin
			item.val = 8'd1;
		end
	end

	assign req.ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign push       = req.valid && req.ready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count overrun");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
`endif

endmodule

// File: design/psgtn_back.sv
// ----------------------------------------------------------------------------
// psgtn_back
// Register file, phase accumulators, noise LFSR, mixer and sample register.
// ----------------------------------------------------------------------------
module psgtn_back import psgtn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_head_t     head,
	output logic        pop,
	psgtn_smp_if.source rsp,
	psgtn_cfg_if.sink   cfg
);

	logic [7:0]        regs_q [NREG];
	logic [ACC_W-1:0]  tacc_q [3];
	logic [2:0]        tlvl_q;
	logic [ACC_W-1:0]  nacc_q;
	logic              nlvl_q;
	logic [LFSR_W-1:0] nsh_q;
	logic [STEP_W-1:0] step_q;
	logic              smp_vld_q;
	logic [SMP_W-1:0]  smp_q;

	logic [CMP_W-1:0]  tper [3];
	logic [ACC_W-1:0]  tsum [3];
	logic [CMP_W-1:0]  tdiff [3];
	logic [2:0]        tfire;
	logic [ACC_W-1:0]  tacc_d [3];
	logic [2:0]        tlvl_d;
	logic [CMP_W-1:0]  nper;
	logic [ACC_W-1:0]  nsum;
	logic [CMP_W-1:0]  ndiff;
	logic              nstep;
	logic [ACC_W-1:0]  nacc_d;
	logic              nlvl_d;
	logic [LFSR_W-1:0] nsh_d;
	logic [SMP_W-1:0]  sum_d;
	logic              out_free;
	logic              do_tick;
	logic              do_write;

	assign cfg.ready  = 1'b1;
	assign rsp.valid  = smp_vld_q;
	assign rsp.sample = smp_q;

	assign out_free = !smp_vld_q || rsp.ready;
	assign pop      = head.valid && (head.item.kind == REQ_WRITE || out_free);
	assign do_tick  = pop && head.item.kind == REQ_TICK;
	assign do_write = pop && head.item.kind == REQ_WRITE;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			tper[j]  = CMP_W'({regs_q[2*j+1], regs_q[2*j]}) << FRAC_BITS;
			tsum[j]  = tacc_q[j] + ACC_W'(step_q);
			tdiff[j] = {{(CMP_W-ACC_W){tsum[j][ACC_W-1]}}, tsum[j]} - tper[j];
			tfire[j] = !tdiff[j][CMP_W-1] && (tdiff[j] != '0);
			if (!tfire[j]) begin
				tacc_d[j] = tsum[j];
				tlvl_d[j] = tlvl_q[j];
			end else if (tper[j] != '0) begin
				tacc_d[j] = tdiff[j][ACC_W-1:0];
				tlvl_d[j] = ~tlvl_q[j];
			end else begin
				tacc_d[j] = '0;
				tlvl_d[j] = 1'b1;
			end
		end

		if (regs_q[REG_NOISE_PER][4:0] == 5'd0) begin
			nper = CMP_W'(1) << (FRAC_BITS + 1);
		end else begin
			nper = CMP_W'(regs_q[REG_NOISE_PER][4:0]) << (FRAC_BITS + 1);
		end
		nsum  = nacc_q + ACC_W'(step_q);
		ndiff = {{(CMP_W-ACC_W){nsum[ACC_W-1]}}, nsum} - nper;
		nstep = (!ndiff[CMP_W-1] && (ndiff != '0)) || (regs_q[REG_NOISE_PER] < 8'd3);
		if (nstep) begin
			nacc_d = ndiff[ACC_W-1:0];
			nsh_d  = {nsh_q[0] ^ nsh_q[3], nsh_q[LFSR_W-1:1]};
			nlvl_d = nsh_q[1];
		end else begin
			nacc_d = nsum;
			nsh_d  = nsh_q;
			nlvl_d = nlvl_q;
		end

		sum_d = '0;
		for (int j = 0; j < 3; j++) begin
			if ((regs_q[REG_MIXER][j] | tlvl_d[j]) & (regs_q[REG_MIXER][j+3] | nlvl_d)) begin
				sum_d = sum_d + SMP_W'(regs_q[8+j][3:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) begin
				regs_q[i] <= '0;
			end
			for (int j = 0; j < 3; j++) begin
				tacc_q[j] <= '0;
			end
			tlvl_q    <= '0;
			nacc_q    <= NOISE_ACC_RESET;
			nlvl_q    <= 1'b0;
			nsh_q     <= LFSR_W'(1);
			step_q    <= STEP_RESET;
			smp_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				step_q <= cfg.phase_step;
			end
			if (do_write) begin
				regs_q[head.item.idx] <= head.item.val;
			end
			if (do_tick) begin
				for (int j = 0; j < 3; j++) begin
					tacc_q[j] <= tacc_d[j];
				end
				tlvl_q    <= tlvl_d;
				nacc_q    <= nacc_d;
				nlvl_q    <= nlvl_d;
				nsh_q     <= nsh_d;
				smp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				smp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			smp_q <= sum_d;
		end
	end

`ifndef SYNTHESIS
	a_tick_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_tick |-> out_free) else $error("tick issued over held sample");
	a_smp_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp_vld_q |-> smp_q <= SMP_W'(45)) else $error("sample out of range");
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		nsh_q != '0) else $error("noise LFSR stuck at zero");
`endif

endmodule

// File: design/psg_tone_noise_mixer_unit.sv
// A tick's request is queued first; its sample is registered when the back end pops it.
// Throughput: one request per cycle, writes and ticks alike; a stalled sample
// holds a tick at the queue head and everything behind it in the two-entry queue.
// Reset: arst_n clears all sound registers, levels and tone accumulators, loads
// the noise accumulator and LFSR seeds and the default phase step; no clear pass.
// ----------------------------------------------------------------------------
// psg_tone_noise_mixer_unit
// Three-voice tone/noise generator top: request front end and tick back end.
// ----------------------------------------------------------------------------
module psg_tone_noise_mixer_unit import psgtn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	psgtn_req_if.sink   req,
	psgtn_smp_if.source rsp,
	psgtn_cfg_if.sink   cfg
);

	q_head_t head;
	logic    pop;

	psgtn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	psgtn_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

// File: dv/psgtn_mix_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psgtn_mix_checker
// Watches the request, step and sample channels of the tone/noise mixer,
// keeps its own copy of the sound registers, accumulators, levels and noise
// LFSR, and compares each sample transfer with the oldest predicted sample.
// ----------------------------------------------------------------------------
module psgtn_mix_checker import psgtn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	psgtn_req_if req,
	psgtn_smp_if rsp,
	psgtn_cfg_if cfg,
	output int   mismatches,
	output int   pending
);

	localparam logic [7:0]       NOISE_PER_MASK = 8'h1f;
	localparam logic [7:0]       NOISE_FORCE_LT = 8'd3;
	localparam logic [IDX_W-1:0] REG_VOL0       = IDX_W'(8);
	localparam int               PRINT_LIMIT    = 100;

	logic [7:0]        sound_regs [NREG];
	logic [ACC_W-1:0]  tone_acc [3];
	logic [ACC_W-1:0]  noise_acc;
	logic [2:0]        tone_lvl;
	logic              noise_lvl;
	logic [LFSR_W-1:0] noise_lfsr;
	logic [STEP_W-1:0] step;
	logic [SMP_W-1:0]  expected_samples [$];

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic bit acc_above(input logic [ACC_W-1:0] acc, input longint unsigned per);
		longint s;
		s = {{(64-ACC_W){acc[ACC_W-1]}}, acc};
		return s > longint'(per);
	endfunction

	task automatic mix_next_sample(output logic [SMP_W-1:0] smp);
		longint unsigned per;
		logic            fb;
		int              sum;
		logic [7:0]      mix;
		for (int j = 0; j < 3; j++) begin
			per = (longint'(sound_regs[2*j]) + (longint'(sound_regs[2*j+1]) << 8)) << FRAC_BITS;
			tone_acc[j] = tone_acc[j] + ACC_W'(step);
			if (acc_above(tone_acc[j], per)) begin
				if (per != 0) begin
					tone_acc[j] = tone_acc[j] - ACC_W'(per);
					tone_lvl[j] = ~tone_lvl[j];
				end else begin
					tone_acc[j] = '0;
					tone_lvl[j] = 1'b1;
				end
			end
		end
		per = longint'(sound_regs[REG_NOISE_PER] & NOISE_PER_MASK) << (FRAC_BITS + 1);
		if (per == 0)
			per = 64'd1 << (FRAC_BITS + 1);
		noise_acc = noise_acc + ACC_W'(step);
		if (acc_above(noise_acc, per) || sound_regs[REG_NOISE_PER] < NOISE_FORCE_LT) begin
			fb = noise_lfsr[0] ^ noise_lfsr[3];
			noise_lfsr = {fb, noise_lfsr[LFSR_W-1:1]};
			noise_lvl = noise_lfsr[0];
			noise_acc = noise_acc - ACC_W'(per);
		end
		mix = sound_regs[REG_MIXER];
		sum = 0;
		for (int j = 0; j < 3; j++) begin
			if ((mix[j] | tone_lvl[j]) & (mix[j+3] | noise_lvl))
				sum += sound_regs[REG_VOL0 + j][3:0];
		end
		smp = SMP_W'(sum);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SMP_W-1:0] want;
		logic [SMP_W-1:0] smp;
		logic [7:0]       val;
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++)
				sound_regs[i] = '0;
			for (int j = 0; j < 3; j++)
				tone_acc[j] = '0;
			noise_acc = NOISE_ACC_RESET;
			tone_lvl = '0;
			noise_lvl = 1'b0;
			noise_lfsr = LFSR_W'(1);
			step = STEP_RESET;
			expected_samples.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d with none expected", rsp.sample));
				end else begin
					want = expected_samples.pop_front();
					if (rsp.sample !== want)
						report_mismatch($sformatf("sample %0d, expected %0d", rsp.sample, want));
				end
			end
			if (cfg.valid && cfg.ready)
				step = cfg.phase_step;
			if (req.valid && req.ready) begin
				if (req_kind_t'(req.req_type) == REQ_TICK) begin
					mix_next_sample(smp);
					expected_samples.push_back(smp);
				end else begin
					val = req.reg_value;
					if (req.reg_index == REG_NOISE_PER && val == 8'd0)
						val = 8'd1;
					sound_regs[req.reg_index] = val;
				end
			end
			pending <= expected_samples.size();
		end
	end

endmodule

// File: dv/tb_psg_tone_noise_mixer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_psg_tone_noise_mixer_unit
// Drives register writes and sample ticks in random bursts across several
// phase-step settings, ending with a back-to-back full-step run over the
// shortest tone periods and the longest noise period; samples are stalled on a
// shifting pattern and checked by psgtn_mix_checker.
// ----------------------------------------------------------------------------
module tb_psg_tone_noise_mixer_unit;
	import psgtn_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int WRAP_TICKS   = 200;
	localparam logic [IDX_W-1:0] REG_TONE0_FINE   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_TONE0_COARSE = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_TONE1_FINE   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_TONE1_COARSE = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_TONE2_FINE   = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_TONE2_COARSE = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_VOL_A        = IDX_W'(8);
	localparam logic [IDX_W-1:0] REG_VOL_B        = IDX_W'(9);
	localparam logic [IDX_W-1:0] REG_VOL_C        = IDX_W'(10);
	localparam logic [IDX_W-1:0] REG_SPARE0       = IDX_W'(11);
	localparam logic [IDX_W-1:0] REG_SPARE1       = IDX_W'(12);
	localparam logic [IDX_W-1:0] REG_SPARE_LAST   = IDX_W'(15);

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   burst_left = 0;
	bit   no_idle = 1'b0;

	logic [15:0] stall_pat = '1;
	int          pat_age = 0;

	psgtn_req_if req_ch();
	psgtn_smp_if smp_ch();
	psgtn_cfg_if cfg_ch();

	psg_tone_noise_mixer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (smp_ch),
		.cfg    (cfg_ch)
	);

	psgtn_mix_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (smp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if (pat_age == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat <= '1;
				1: stall_pat <= 16'($urandom);
				2: stall_pat <= 16'($urandom) | 16'($urandom);
				default: stall_pat <= 16'($urandom) & 16'($urandom);
			endcase
			pat_age <= $urandom_range(16, 64);
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
			pat_age <= pat_age - 1;
		end
		smp_ch.ready <= stall_pat[0];
	end

	task automatic send_req(input req_kind_t kind, input logic [IDX_W-1:0] idx,
			input logic [7:0] val);
		int gap;
		if (burst_left == 0 && !no_idle) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.reg_index <= idx;
		req_ch.reg_value <= val;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
		send_req(REQ_WRITE, idx, val);
	endtask

	task automatic tick();
		send_req(REQ_TICK, IDX_W'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_step(input logic [STEP_W-1:0] value);
		drain();
		cfg_ch.valid      <= 1'b1;
		cfg_ch.phase_step <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	initial begin
		#60_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [STEP_W-1:0] phase_steps [PHASES];
		logic [IDX_W-1:0]  idx;
		logic [7:0]        val;
		int                pick;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_WRITE;
		req_ch.reg_index  = '0;
		req_ch.reg_value  = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.phase_step = '0;
		smp_ch.ready      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at the reset step
		tick();
		write_reg(REG_VOL_A, 8'hff);
		write_reg(REG_VOL_B, 8'h0f);
		write_reg(REG_VOL_C, 8'hf0);
		write_reg(REG_MIXER, 8'hff);
		tick();
		write_reg(REG_VOL_C, 8'h0f);
		tick();
		write_reg(REG_NOISE_PER, 8'h00);
		tick();
		tick();
		write_reg(REG_MIXER, 8'h00);
		tick();
		write_reg(REG_TONE0_FINE, 8'hff);
		write_reg(REG_TONE0_COARSE, 8'hff);
		write_reg(REG_TONE1_FINE, 8'h01);
		tick();
		write_reg(REG_NOISE_PER, 8'hff);
		tick();
		write_reg(REG_NOISE_PER, 8'h02);
		tick();
		write_reg(REG_MIXER, 8'hc0);
		write_reg(REG_SPARE0, 8'haa);
		write_reg(REG_SPARE_LAST, 8'h55);
		write_reg(REG_SPARE1, 8'hff);
		tick();
		tick();

		phase_steps[0] = '0;
		phase_steps[1] = '1;
		phase_steps[2] = STEP_W'(1);
		phase_steps[3] = STEP_W'(65536);
		phase_steps[4] = STEP_W'($urandom_range(2, 65535));
		phase_steps[5] = STEP_W'($urandom_range(65536, 1 << 20));
		phase_steps[6] = STEP_W'($urandom);
		phase_steps[7] = STEP_RESET;

		for (int p = 0; p < PHASES; p++) begin
			set_step(phase_steps[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 199) == 0)
					drain();
				if ($urandom_range(0, 99) < 62) begin
					tick();
				end else begin
					pick = $urandom_range(0, 9);
					val = 8'($urandom);
					case (pick)
						0, 1, 2: begin
							idx = IDX_W'(2 * $urandom_range(0, 2));
							if ($urandom_range(0, 3) != 0)
								val = 8'($urandom_range(0, 40));
						end
						3: begin
							idx = IDX_W'(2 * $urandom_range(0, 2) + 1);
							if ($urandom_range(0, 3) != 0)
								val = '0;
						end
						4: begin
							idx = REG_NOISE_PER;
							if ($urandom_range(0, 1) == 0)
								val = 8'($urandom_range(0, 4));
						end
						5, 6: idx = REG_MIXER;
						7, 8: idx = IDX_W'($urandom_range(8, 10));
						default: idx = IDX_W'($urandom);
					endcase
					write_reg(idx, val);
				end
			end
		end

		// full step over the shortest tone periods and the longest noise period, back to back
		set_step('1);
		write_reg(REG_TONE0_FINE, 8'h01);
		write_reg(REG_TONE0_COARSE, 8'h00);
		write_reg(REG_TONE1_FINE, 8'h01);
		write_reg(REG_TONE1_COARSE, 8'h00);
		write_reg(REG_TONE2_FINE, 8'h01);
		write_reg(REG_TONE2_COARSE, 8'h00);
		write_reg(REG_NOISE_PER, 8'h1f);
		write_reg(REG_MIXER, 8'h00);
		write_reg(REG_VOL_A, 8'h0f);
		write_reg(REG_VOL_B, 8'h07);
		write_reg(REG_VOL_C, 8'h0c);
		no_idle = 1'b1;
		for (int n = 0; n < WRAP_TICKS; n++)
			tick();
		no_idle = 1'b0;

		drain();
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
